[design/lpct_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, register codes, trig table and output conversion for the lidar point block.
package lpct_pkg;

  // Default scan geometry.
  localparam int BEAM_COUNT_DEF  = 1080;
  localparam int FRONT_INDEX_DEF = 540;

  // Field widths.
  localparam int INDEX_W = 11;
  localparam int RANGE_W = 16;
  localparam int COEF_W  = 16;
  localparam int POINT_W = 18;
  localparam int ANGLE_W = 13;

  // Angles are counted in quarter degrees.
  localparam logic signed [ANGLE_W-1:0] FULL_TURN = 13'sd1440;
  localparam logic [10:0] QUARTER_TURN = 11'd360;
  localparam logic [10:0] HALF_TURN    = 11'd720;
  localparam logic [10:0] THREE_QUARTER_TURN = 11'd1080;
  localparam logic [8:0]  OCTANT       = 9'd180;
  localparam logic [8:0]  QUARTER_F    = 9'd360;
  localparam logic [10:0] QDEG_80      = 11'd320;
  localparam logic [10:0] QDEG_90      = 11'd360;
  localparam logic [10:0] QDEG_130     = 11'd520;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_COS_ROLL  = 3'd0,
    REG_SIN_ROLL  = 3'd1,
    REG_COS_PITCH = 3'd2,
    REG_SIN_PITCH = 3'd3,
    REG_MAX_RANGE = 3'd4,
    REG_OFFSET_Z  = 3'd5,
    REG_OFFSET_X  = 3'd6
  } cfg_reg_t;

  // Register reset values.
  localparam logic signed [COEF_W-1:0] COS_RESET   = 16'sd32767;
  localparam logic signed [COEF_W-1:0] SIN_RESET   = 16'sd0;
  localparam logic [RANGE_W-1:0]       RANGE_RESET = 16'd6000;

  // Quadrant of the folded beam angle.
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // First-octant table: 0 to 45 degrees in quarter-degree steps.
  localparam int ROM_LAST = 180;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef logic [29:0] trig_rom_t [0:ROM_LAST];

  // Returns {sine, cosine} magnitudes in Q15 for m quarter degrees, built from a
  // Taylor series in Q30 and rounded half up.
  function automatic logic [29:0] trig_entry(input int unsigned m);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] s;
    logic [63:0] c;
    logic [63:0] rs;
    logic [63:0] rc;
    x  = (64'(m) * PI_Q30) / 64'd720;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd72;
    u  = Q30_ONE - x2 / 64'd90;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    u  = Q30_ONE - ((x2 * u) >> 30) / 64'd56;
    u  = Q30_ONE - ((x2 * u) >> 30) / 64'd30;
    u  = Q30_ONE - ((x2 * u) >> 30) / 64'd12;
    u  = Q30_ONE - ((x2 * u) >> 30) / 64'd2;
    c  = u;
    rs = (s + 64'd16384) >> 15;
    rc = (c + 64'd16384) >> 15;
    if (rs > 64'd32767) begin
      rs = 64'd32767;
    end
    if (rc > 64'd32767) begin
      rc = 64'd32767;
    end
    return {rs[14:0], rc[14:0]};
  endfunction

  function automatic trig_rom_t build_trig_rom();
    trig_rom_t rom;
    for (int m = 0; m <= ROM_LAST; m++) begin
      rom[m] = trig_entry(m);
    end
    return rom;
  endfunction

  localparam trig_rom_t TRIG_ROM = build_trig_rom();

  // Divides a Q45 value by 2^45 toward zero and saturates to the point range.
  function automatic logic signed [POINT_W-1:0] to_point(input logic signed [63:0] v);
    logic signed [63:0] bias;
    logic signed [63:0] sh;
    logic signed [18:0] q;
    bias = v[63] ? ((64'sd1 <<< 45) - 64'sd1) : 64'sd0;
    sh   = (v + bias) >>> 45;
    q    = sh[18:0];
    if (q > 19'sd131071) begin
      return 18'sd131071;
    end else if (q < -19'sd131072) begin
      return -18'sd131072;
    end
    return q[17:0];
  endfunction

endpackage

[design/lidar_polar_to_cartesian_tilt.sv]
`timescale 1ns / 1ps
// Pipelined polar-to-Cartesian conversion of scanner samples with mounting offsets and tilt.
//
// Each sample word (beam_index, range_mm) becomes one point word (point_y, point_z,
// point_valid) on the point port once it has passed all the stages, and a new
// sample can be accepted in every cycle while the point port is not stalled, so
// the sustained rate is one word per clock. The seven register stages, the first
// loaded at the accepting edge, are: angle and mask checks, quadrant fold, trig
// table lookup, range products, rotation products, sums, and the truncating
// saturated output register. Each stage advances on its own, so a stall at the result
// port only backs up as far as the pipeline is full and bubbles are squeezed out. The beam
// sine and cosine come from a 181-entry constant table of the first octant
// (0 to 45 degrees, quarter-degree steps) unfolded by symmetry, so there is no
// memory to fill and no start-up pass after reset. Beams between 80 and 90
// degrees, beyond 130 degrees, past the end of the scan, or with a range above
// max_range give a zero point with point_valid low. The roll and pitch cross
// products are held in registers loaded from the configuration registers; configuration
// is always ready and is meant to be written while the pipeline is empty.
module lidar_polar_to_cartesian_tilt
  import lpct_pkg::*;
#(
  parameter int BEAM_COUNT  = BEAM_COUNT_DEF,
  parameter int FRONT_INDEX = FRONT_INDEX_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // Sample channel.
  input  logic                       sample_valid,
  output logic                       sample_ready,
  input  logic [INDEX_W-1:0]         beam_index,
  input  logic [RANGE_W-1:0]         range_mm,
  // Point channel.
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic signed [POINT_W-1:0]  point_y,
  output logic signed [POINT_W-1:0]  point_z,
  output logic                       point_valid,
  // Configuration write channel.
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [15:0]                cfg_data
);

  localparam int NSTAGE = 7;
  localparam logic signed [ANGLE_W-1:0] FRONT_S = ANGLE_W'(FRONT_INDEX);
  localparam logic [INDEX_W:0] BEAM_LIMIT = (INDEX_W + 1)'(BEAM_COUNT);

  // Configuration registers.
  logic signed [COEF_W-1:0] roll_cos;
  logic signed [COEF_W-1:0] roll_sin;
  logic signed [COEF_W-1:0] pitch_cos;
  logic signed [COEF_W-1:0] pitch_sin;
  logic [RANGE_W-1:0]       max_range;
  logic signed [COEF_W-1:0] offset_z;
  logic signed [COEF_W-1:0] offset_x;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_cos  <= COS_RESET;
      roll_sin  <= SIN_RESET;
      pitch_cos <= COS_RESET;
      pitch_sin <= SIN_RESET;
      max_range <= RANGE_RESET;
      offset_z  <= SIN_RESET;
      offset_x  <= SIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COS_ROLL:  roll_cos  <= cfg_data;
        REG_SIN_ROLL:  roll_sin  <= cfg_data;
        REG_COS_PITCH: pitch_cos <= cfg_data;
        REG_SIN_PITCH: pitch_sin <= cfg_data;
        REG_MAX_RANGE: max_range <= cfg_data;
        REG_OFFSET_Z:  offset_z  <= cfg_data;
        REG_OFFSET_X:  offset_x  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Products of configuration values only, each registered; ky and kz take srsp and crsp.
  logic signed [31:0] cpsr;
  logic signed [31:0] cpcr;
  logic signed [31:0] srsp;
  logic signed [31:0] crsp;
  logic signed [47:0] ky;
  logic signed [47:0] kz;

  always_ff @(posedge clk) begin
    cpsr <= pitch_cos * roll_sin;
    cpcr <= pitch_cos * roll_cos;
    srsp <= roll_sin * pitch_sin;
    crsp <= roll_cos * pitch_sin;
    ky   <= offset_x * srsp;
    kz   <= offset_x * crsp;
  end

  // Pipeline valid bits and per-stage advance enables.
  logic [NSTAGE:1] vld;
  logic [NSTAGE:1] adv;

  always_comb begin
    adv[NSTAGE] = !vld[NSTAGE] || result_ready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign sample_ready = adv[1];
  assign result_valid = vld[NSTAGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= sample_valid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: signed beam angle, its magnitude for the mask, and the angle
  // wrapped into one turn.
  logic signed [ANGLE_W-1:0] ang;
  logic [10:0]               ang_abs;
  logic [10:0]               wrap_next;
  logic                      ok_next;
  logic [10:0]               s1_wrap;
  logic [RANGE_W-1:0]        s1_range;
  logic                      s1_ok;

  always_comb begin
    ang     = $signed({2'b00, beam_index}) - FRONT_S;
    ang_abs = ang[ANGLE_W-1] ? 11'(-ang) : 11'(ang);
    if (ang[ANGLE_W-1]) begin
      wrap_next = 11'(ang + FULL_TURN);
    end else if (ang >= FULL_TURN) begin
      wrap_next = 11'(ang - FULL_TURN);
    end else begin
      wrap_next = 11'(ang);
    end
    ok_next = ({1'b0, beam_index} < BEAM_LIMIT) &&
              !(ang_abs > QDEG_80 && ang_abs < QDEG_90) &&
              !(ang_abs > QDEG_130) &&
              (range_mm <= max_range);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_wrap  <= wrap_next;
      s1_range <= range_mm;
      s1_ok    <= ok_next;
    end
  end

  // Stage 2: split into quadrant and offset, then fold the offset into the
  // first octant; past 45 degrees sine and cosine trade places.
  quad_t              quad_next;
  logic [8:0]         frac;
  logic               swap_next;
  logic [7:0]         oct_next;
  quad_t              s2_quad;
  logic               s2_swap;
  logic [7:0]         s2_oct;
  logic [RANGE_W-1:0] s2_range;
  logic               s2_ok;

  always_comb begin
    if (s1_wrap >= THREE_QUARTER_TURN) begin
      quad_next = QUAD_3;
      frac      = 9'(s1_wrap - THREE_QUARTER_TURN);
    end else if (s1_wrap >= HALF_TURN) begin
      quad_next = QUAD_2;
      frac      = 9'(s1_wrap - HALF_TURN);
    end else if (s1_wrap >= QUARTER_TURN) begin
      quad_next = QUAD_1;
      frac      = 9'(s1_wrap - QUARTER_TURN);
    end else begin
      quad_next = QUAD_0;
      frac      = 9'(s1_wrap);
    end
    swap_next = frac > OCTANT;
    oct_next  = swap_next ? 8'(QUARTER_F - frac) : 8'(frac);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_quad  <= quad_next;
      s2_swap  <= swap_next;
      s2_oct   <= oct_next;
      s2_range <= s1_range;
      s2_ok    <= s1_ok;
    end
  end

  // Stage 3: table lookup and quadrant signs.
  logic [29:0]              entry;
  logic [14:0]              mag_s;
  logic [14:0]              mag_c;
  logic signed [COEF_W-1:0] pos_s;
  logic signed [COEF_W-1:0] pos_c;
  logic signed [COEF_W-1:0] sin_next;
  logic signed [COEF_W-1:0] cos_next;
  logic signed [COEF_W-1:0] s3_sin;
  logic signed [COEF_W-1:0] s3_cos;
  logic [RANGE_W-1:0]       s3_range;
  logic                     s3_ok;

  always_comb begin
    entry = TRIG_ROM[s2_oct];
    mag_s = s2_swap ? entry[14:0] : entry[29:15];
    mag_c = s2_swap ? entry[29:15] : entry[14:0];
    pos_s = $signed({1'b0, mag_s});
    pos_c = $signed({1'b0, mag_c});
    case (s2_quad)
      QUAD_0: begin
        sin_next = pos_s;
        cos_next = pos_c;
      end
      QUAD_1: begin
        sin_next = pos_c;
        cos_next = -pos_s;
      end
      QUAD_2: begin
        sin_next = -pos_s;
        cos_next = -pos_c;
      end
      QUAD_3: begin
        sin_next = -pos_c;
        cos_next = pos_s;
      end
      default: begin
        sin_next = pos_s;
        cos_next = pos_c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_sin   <= sin_next;
      s3_cos   <= cos_next;
      s3_range <= s2_range;
      s3_ok    <= s2_ok;
    end
  end

  // Stage 4: raw y and z in Q15, with the vertical offset taken off z.
  logic signed [RANGE_W:0] range_s;
  logic signed [32:0]      ty_next;
  logic signed [32:0]      rc;
  logic signed [33:0]      tz_next;
  logic signed [32:0]      s4_ty;
  logic signed [33:0]      s4_tz;
  logic                    s4_ok;

  always_comb begin
    range_s = $signed({1'b0, s3_range});
    ty_next = range_s * s3_sin;
    rc      = range_s * s3_cos;
    tz_next = 34'(rc) - (34'(offset_z) <<< 15);
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_ty <= ty_next;
      s4_tz <= tz_next;
      s4_ok <= s3_ok;
    end
  end

  // Stage 5: rotation products.
  logic signed [48:0] py1_next;
  logic signed [48:0] pz1_next;
  logic signed [65:0] py2_full;
  logic signed [65:0] pz2_full;
  logic signed [48:0] s5_py1;
  logic signed [48:0] s5_pz1;
  logic signed [63:0] s5_py2;
  logic signed [63:0] s5_pz2;
  logic               s5_ok;

  always_comb begin
    py1_next = roll_cos * s4_ty;
    pz1_next = roll_sin * s4_ty;
    py2_full = cpsr * s4_tz;
    pz2_full = cpcr * s4_tz;
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_py1 <= py1_next;
      s5_pz1 <= pz1_next;
      s5_py2 <= $signed(py2_full[63:0]);
      s5_pz2 <= $signed(pz2_full[63:0]);
      s5_ok  <= s4_ok;
    end
  end

  // Stage 6: Q45 sums.
  logic signed [63:0] ysum;
  logic signed [63:0] zsum;
  logic signed [63:0] s6_y;
  logic signed [63:0] s6_z;
  logic               s6_ok;

  always_comb begin
    ysum = (64'(s5_py1) <<< 15) - s5_py2 + (64'(ky) <<< 15);
    zsum = (64'(s5_pz1) <<< 15) + s5_pz2 - (64'(kz) <<< 15);
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_y  <= ysum;
      s6_z  <= zsum;
      s6_ok <= s5_ok;
    end
  end

  // Stage 7: truncate toward zero, saturate, and zero rejected samples.
  always_ff @(posedge clk) begin
    if (adv[7]) begin
      point_y     <= s6_ok ? to_point(s6_y) : '0;
      point_z     <= s6_ok ? to_point(s6_z) : '0;
      point_valid <= s6_ok;
    end
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the lidar polar-to-Cartesian point block.
module tb_top;
  import lpct_pkg::*;

  // The limit is far above the length of a normal run and leaves a wide margin
  // for long random gaps on either side of the block.
  localparam int TIMEOUT_CYCLES  = 200000;
  localparam int PHASE_COUNT     = 8;
  localparam int ITEMS_PER_PHASE = 194;
  // The pipeline is seven stages deep, so this many quiet cycles are enough
  // for any late or stray word to show up before the registers are touched.
  localparam int DRAIN_CYCLES    = 16;
  // Index that no register answers to. A write to it must change nothing.
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam longint Q45_ONE = 64'sd1 <<< 45;
  localparam longint POINT_MAX = 131071;
  localparam longint POINT_MIN = -131072;

  typedef struct packed {
    logic signed [POINT_W-1:0] y;
    logic signed [POINT_W-1:0] z;
    logic                      valid;
  } point_t;

  typedef struct packed {
    logic [15:0] roll_cos;
    logic [15:0] roll_sin;
    logic [15:0] pitch_cos;
    logic [15:0] pitch_sin;
    logic [15:0] max_range;
    logic [15:0] offset_z;
    logic [15:0] offset_x;
  } reg_set_t;

  typedef struct packed {
    logic [INDEX_W-1:0] beam;
    logic [RANGE_W-1:0] rng_mm;
    logic               typed;
    point_t             point;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      sample_valid = 1'b0;
  logic                      sample_ready;
  logic [INDEX_W-1:0]        beam_index = '0;
  logic [RANGE_W-1:0]        range_mm = '0;
  logic                      result_valid;
  logic                      result_ready = 1'b0;
  logic signed [POINT_W-1:0] point_y;
  logic signed [POINT_W-1:0] point_z;
  logic                      point_valid;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [2:0]                cfg_index = '0;
  logic [15:0]               cfg_data = '0;

  // Our own copy of the register file, updated when a write word is accepted.
  reg_set_t live_cfg = '{COS_RESET, SIN_RESET, COS_RESET, SIN_RESET, RANGE_RESET,
                         16'd0, 16'd0};

  // Beam sine and cosine in Q1.15, rebuilt here from the Taylor series.
  logic signed [15:0] beam_sin [BEAM_COUNT_DEF];
  logic signed [15:0] beam_cos [BEAM_COUNT_DEF];

  point_t    expected_points [$];
  stim_row_t directed_rows [$];
  int        fail_count    = 0;
  int        cycle_count   = 0;
  int        src_idle_pct  = 0;
  int        snk_stall_pct = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  lidar_polar_to_cartesian_tilt u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .beam_index   (beam_index),
    .range_mm     (range_mm),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .point_y      (point_y),
    .point_z      (point_z),
    .point_valid  (point_valid),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Sine and cosine in Q30 of m quarter degrees, m between 0 and 45 degrees.
  // The series is evaluated in Horner form with plain truncating shifts.
  function automatic void octant_q30(input int unsigned m, output longint unsigned s,
                                     output longint unsigned c);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned u;
    x  = (64'(m) * PI_Q30) / 64'd720;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    u  = Q30_ONE - x2 / 64'd90;
    u  = Q30_ONE - ((x2 * u) >> 30) / 64'd56;
    u  = Q30_ONE - ((x2 * u) >> 30) / 64'd30;
    u  = Q30_ONE - ((x2 * u) >> 30) / 64'd12;
    u  = Q30_ONE - ((x2 * u) >> 30) / 64'd2;
    c  = u;
  endfunction

  // Rounds a Q30 magnitude half up to Q15 and caps it just below one.
  function automatic logic signed [15:0] q15_magnitude(input longint unsigned v);
    longint unsigned r;
    r = (v + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[15:0];
  endfunction

  // Folds an angle in quarter degrees into the first octant, then unfolds the
  // rounded magnitudes by quadrant. The sign goes on after rounding.
  function automatic void beam_trig(input int angle, output logic signed [15:0] sn,
                                    output logic signed [15:0] cs);
    int              r;
    int unsigned     f;
    longint unsigned s;
    longint unsigned c;
    logic signed [15:0] ms;
    logic signed [15:0] mc;
    quad_t           quad;
    r = angle % 1440;
    if (r < 0) begin
      r += 1440;
    end
    quad = quad_t'(2'(r / 360));
    f    = r % 360;
    if (f <= 180) begin
      octant_q30(f, s, c);
    end else begin
      octant_q30(360 - f, c, s);
    end
    ms = q15_magnitude(s);
    mc = q15_magnitude(c);
    case (quad)
      QUAD_0: begin
        sn = ms;
        cs = mc;
      end
      QUAD_1: begin
        sn = mc;
        cs = -ms;
      end
      QUAD_2: begin
        sn = -ms;
        cs = -mc;
      end
      default: begin
        sn = -mc;
        cs = ms;
      end
    endcase
  endfunction

  function automatic logic signed [POINT_W-1:0] clip_point(input longint v);
    if (v > POINT_MAX) begin
      v = POINT_MAX;
    end else if (v < POINT_MIN) begin
      v = POINT_MIN;
    end
    return v[POINT_W-1:0];
  endfunction

  // Expected point word for one sample word under the current registers.
  function automatic point_t predict_point(input logic [INDEX_W-1:0] beam,
                                           input logic [RANGE_W-1:0] rng_mm);
    int     k;
    int     ak;
    longint rl;
    longint sn;
    longint cs;
    longint cr;
    longint sr;
    longint cp;
    longint sp;
    longint oz;
    longint ox;
    longint ty;
    longint tz;
    longint y;
    longint z;
    point_t pt;
    pt = '0;
    if (beam >= BEAM_COUNT_DEF) begin
      return pt;
    end
    k  = int'(beam) - FRONT_INDEX_DEF;
    ak = (k < 0) ? -k : k;
    // Angle mask: the 80 to 90 degree gap and everything past 130 degrees,
    // with the boundaries at 80, 90 and 130 degrees themselves kept.
    if ((ak > QDEG_80 && ak < QDEG_90) || ak > QDEG_130 || rng_mm > live_cfg.max_range) begin
      return pt;
    end
    rl = rng_mm;
    sn = beam_sin[beam];
    cs = beam_cos[beam];
    cr = $signed(live_cfg.roll_cos);
    sr = $signed(live_cfg.roll_sin);
    cp = $signed(live_cfg.pitch_cos);
    sp = $signed(live_cfg.pitch_sin);
    oz = $signed(live_cfg.offset_z);
    ox = $signed(live_cfg.offset_x);
    // Everything is exact in Q45 and fits in 64 bits even at the extremes.
    ty = rl * sn;
    tz = rl * cs - oz * 32768;
    y  = cr * ty * 32768 - (cp * sr) * tz + ox * (sr * sp) * 32768;
    z  = sr * ty * 32768 + (cp * cr) * tz - ox * (cr * sp) * 32768;
    // Signed division truncates toward zero, as the block does.
    pt.y     = clip_point(y / Q45_ONE);
    pt.z     = clip_point(z / Q45_ONE);
    pt.valid = 1'b1;
    return pt;
  endfunction

  // Beam index that passes the angle mask.
  function automatic logic [INDEX_W-1:0] pick_open_beam();
    int k;
    int ak;
    do begin
      k  = int'($urandom_range(0, 2 * QDEG_130)) - int'(QDEG_130);
      ak = (k < 0) ? -k : k;
    end while (ak > QDEG_80 && ak < QDEG_90);
    return INDEX_W'(FRONT_INDEX_DEF + k);
  endfunction

  // Register settings for each phase: the reset values written back, both
  // corners of the coefficient and offset ranges, a phase that rejects every
  // nonzero range, and then fully random settings.
  function automatic reg_set_t plan_for_phase(input int phase);
    reg_set_t rs;
    rs = 112'({$urandom, $urandom, $urandom, $urandom});
    case (phase)
      0: rs = '{COS_RESET, SIN_RESET, COS_RESET, SIN_RESET, RANGE_RESET, 16'd0, 16'd0};
      1: rs = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'h8000, 16'h8000};
      2: rs = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'h7FFF};
      3: rs.max_range = 16'd0;
      default: ;
    endcase
    return rs;
  endfunction

  // Writes one register word. cfg_valid is left high so that back-to-back
  // writes never lower and raise it in the same step; the caller drops it.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_COS_ROLL:  live_cfg.roll_cos  = data;
      REG_SIN_ROLL:  live_cfg.roll_sin  = data;
      REG_COS_PITCH: live_cfg.pitch_cos = data;
      REG_SIN_PITCH: live_cfg.pitch_sin = data;
      REG_MAX_RANGE: live_cfg.max_range = data;
      REG_OFFSET_Z:  live_cfg.offset_z  = data;
      REG_OFFSET_X:  live_cfg.offset_x  = data;
      default: ;
    endcase
  endtask

  task automatic program_regs(input reg_set_t rs);
    write_reg(REG_UNUSED, 16'($urandom));
    write_reg(REG_COS_ROLL, rs.roll_cos);
    write_reg(REG_SIN_ROLL, rs.roll_sin);
    write_reg(REG_COS_PITCH, rs.pitch_cos);
    write_reg(REG_SIN_PITCH, rs.pitch_sin);
    write_reg(REG_MAX_RANGE, rs.max_range);
    write_reg(REG_OFFSET_Z, rs.offset_z);
    write_reg(REG_OFFSET_X, rs.offset_x);
    cfg_valid <= 1'b0;
  endtask

  // Sends one sample word. Idle cycles come before the word, never inside a
  // handshake. sample_valid stays high after acceptance so that a following
  // word can go out in the very next cycle; whoever stops sending lowers it.
  task automatic send_sample(input logic [INDEX_W-1:0] beam, input logic [RANGE_W-1:0] rng_mm,
                             input logic typed, input point_t typed_point);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    beam_index   <= beam;
    range_mm     <= rng_mm;
    do @(posedge clk); while (!sample_ready);
    // Registers are steady while samples are in flight, so the prediction can
    // be formed right at acceptance.
    expected_points.insert(expected_points.size(),
                           typed ? typed_point : predict_point(beam, rng_mm));
  endtask

  task automatic add_row(input int beam, input int rng_mm, input logic typed);
    stim_row_t row;
    row.beam   = INDEX_W'(beam);
    row.rng_mm = RANGE_W'(rng_mm);
    row.typed  = typed;
    // Typed rows here are zero range at boresight or rejected samples: the
    // zero range gives a valid point at the origin, a reject gives all zeros.
    row.point  = '{'0, '0, (rng_mm == 0)};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Point word checker and receiver. ready is redrawn every cycle against the
  // stall percentage of the current phase; the word itself is compared with
  // the oldest prediction field by field.
  always @(posedge clk) begin
    point_t exp_pt;
    if (!rst && result_valid && result_ready) begin
      if (expected_points.size() == 0) begin
        $error("unexpected point word: point_y %0d point_z %0d point_valid %0d",
               point_y, point_z, point_valid);
        fail_count++;
      end else begin
        exp_pt = expected_points[0];
        expected_points.delete(0);
        if (point_y !== exp_pt.y) begin
          $error("point_y mismatch: expected %0d, actual %0d", exp_pt.y, point_y);
          fail_count++;
        end
        if (point_z !== exp_pt.z) begin
          $error("point_z mismatch: expected %0d, actual %0d", exp_pt.z, point_z);
          fail_count++;
        end
        if (point_valid !== exp_pt.valid) begin
          $error("point_valid mismatch: expected %0d, actual %0d", exp_pt.valid, point_valid);
          fail_count++;
        end
      end
    end
    result_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // Watchdog for a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [INDEX_W-1:0] beam;
    logic [RANGE_W-1:0] rng_mm;
    for (int i = 0; i < BEAM_COUNT_DEF; i++) begin
      beam_trig(i - FRONT_INDEX_DEF, beam_sin[i], beam_cos[i]);
    end

    // Directed samples, all under the reset registers: boresight ranges around
    // the 6000 mm limit, both edges of every mask zone on either side, the
    // ends of the scan, indexes past the table, and all-ones fields.
    add_row(540, 0, 1'b1);
    add_row(540, 1000, 1'b0);
    add_row(540, 6000, 1'b0);
    add_row(540, 6001, 1'b1);
    add_row(540, 65535, 1'b1);
    add_row(860, 1000, 1'b0);
    add_row(861, 1000, 1'b1);
    add_row(899, 1000, 1'b1);
    add_row(900, 1000, 1'b0);
    add_row(1060, 1000, 1'b0);
    add_row(1061, 1000, 1'b1);
    add_row(220, 1000, 1'b0);
    add_row(219, 1000, 1'b1);
    add_row(181, 1000, 1'b1);
    add_row(180, 1000, 1'b0);
    add_row(20, 1000, 1'b0);
    add_row(19, 1000, 1'b1);
    add_row(0, 2000, 1'b1);
    add_row(1079, 2000, 1'b1);
    add_row(1080, 100, 1'b1);
    add_row(2047, 65535, 1'b1);
    add_row(700, 4321, 1'b0);
    add_row(380, 5999, 1'b0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].beam, directed_rows[i].rng_mm, directed_rows[i].typed,
                  directed_rows[i].point);
    end
    sample_valid <= 1'b0;

    // Random phases. Each one drains the pipeline, reprograms every register
    // and then streams samples under one of four idling patterns: none, a
    // lazy sender, a stalling receiver, and light idling on both sides.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      while (expected_points.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
      program_regs(plan_for_phase(phase));
      case (phase % 4)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 45;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 45;
        end
        default: begin
          src_idle_pct  = 6;
          snk_stall_pct = 6;
        end
      endcase
      repeat (ITEMS_PER_PHASE) begin
        // Most samples are in the open part of the scan and within range, a
        // tenth of those right at the limit; the rest are raw random fields.
        if ($urandom_range(0, 99) < 70) begin
          beam = pick_open_beam();
          if ($urandom_range(0, 9) == 0) begin
            rng_mm = live_cfg.max_range;
          end else begin
            rng_mm = RANGE_W'($urandom_range(0, live_cfg.max_range));
          end
        end else begin
          beam   = INDEX_W'($urandom);
          rng_mm = RANGE_W'($urandom);
        end
        send_sample(beam, rng_mm, 1'b0, '0);
      end
      sample_valid <= 1'b0;
    end

    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
design/lpct_pkg.sv
design/lidar_polar_to_cartesian_tilt.sv
dv/tb_top.sv
